// ----- sv/telemetry_frame_encoder_defines.svh -----
// Assertion macros for the telemetry frame encoder.
`ifndef TELEMETRY_FRAME_ENCODER_DEFINES_SVH
`define TELEMETRY_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TFE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("telemetry_frame_encoder: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TFE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("telemetry_frame_encoder: next-cycle check failed");

`else

`define TFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define TFE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/tfe_pkg.sv -----
// Types, constants and control store of the telemetry frame encoder.
`default_nettype none

package tfe_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] TYPE_RESET = 8'h10;

  // Byte source selects of the datapath mux.
  typedef logic [2:0] tfe_sel_t;
  localparam tfe_sel_t SEL_TYPE  = 3'd0;
  localparam tfe_sel_t SEL_ID_LO = 3'd1;
  localparam tfe_sel_t SEL_ID_HI = 3'd2;
  localparam tfe_sel_t SEL_VAL0  = 3'd3;
  localparam tfe_sel_t SEL_VAL1  = 3'd4;
  localparam tfe_sel_t SEL_VAL2  = 3'd5;
  localparam tfe_sel_t SEL_VAL3  = 3'd6;
  localparam tfe_sel_t SEL_CSUM  = 3'd7;

  typedef logic [2:0] tfe_pc_t;

  // One control word per frame byte.
  typedef struct packed {
    tfe_sel_t sel;
    logic     acc;   // fold the byte into the checksum
    logic     last;  // final byte of the frame
    logic     done;  // end of program, return to idle
  } tfe_uop_t;

  function automatic tfe_uop_t tfe_rom(input tfe_pc_t pc);
    tfe_uop_t w;
    case (pc)
      3'd0:    w = '{sel: SEL_TYPE,  acc: 1'b1, last: 1'b0, done: 1'b0};
      3'd1:    w = '{sel: SEL_ID_LO, acc: 1'b1, last: 1'b0, done: 1'b0};
      3'd2:    w = '{sel: SEL_ID_HI, acc: 1'b1, last: 1'b0, done: 1'b0};
      3'd3:    w = '{sel: SEL_VAL0,  acc: 1'b1, last: 1'b0, done: 1'b0};
      3'd4:    w = '{sel: SEL_VAL1,  acc: 1'b1, last: 1'b0, done: 1'b0};
      3'd5:    w = '{sel: SEL_VAL2,  acc: 1'b1, last: 1'b0, done: 1'b0};
      3'd6:    w = '{sel: SEL_VAL3,  acc: 1'b1, last: 1'b0, done: 1'b0};
      default: w = '{sel: SEL_CSUM,  acc: 1'b0, last: 1'b1, done: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tfe_channels.sv -----
// Valid/ready channel interfaces of the telemetry frame encoder.
`default_nettype none

interface tfe_item_if;
  logic               valid;
  logic               ready;
  logic [15:0]        sensor_id;
  logic signed [31:0] sensor_value;
  modport source (output valid, output sensor_id, output sensor_value, input ready);
  modport sink   (input valid, input sensor_id, input sensor_value, output ready);
endinterface

interface tfe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

interface tfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  modport source (output valid, output frame_type, input ready);
  modport sink   (input valid, input frame_type, output ready);
endinterface

`default_nettype wire

// ----- sv/telemetry_frame_encoder.sv -----
// Telemetry frame encoder: one sensor reading in, one byte-stuffed frame out.
//
// item  : sink of (sensor_id, sensor_value) beats. One beat starts one frame.
// frame : source of line bytes; last_byte marks the final beat of a frame.
// cfg   : write channel for the frame type byte, always ready; write it idle.
//
// A frame is the type byte, id and value low byte first, and the checksum,
// with 0x7D/0x7E escaped as a two-byte pair, so 8 to 16 beats long.
// An eight-word control program steps one frame byte per word; an escape
// holds its word for a second step, 0x7D first and then the byte XOR 0x20.
// Once the item beat is taken, busy is set and the first step loads the
// first byte into the output register, then one byte per cycle while the
// receiver takes them. The next item is taken the cycle after the last
// byte is loaded. When frame.ready is low the output register holds its
// beat and the sequencer waits. Reset empties the output, stops any frame
// in flight and sets the frame type to 0x10.
`default_nettype none

module telemetry_frame_encoder (
  input  wire logic   clk,
  input  wire logic   rst,
  tfe_item_if.sink    item,
  tfe_frame_if.source frame,
  tfe_cfg_if.sink     cfg
);
  import tfe_pkg::*;

  `include "telemetry_frame_encoder_defines.svh"

  logic [7:0]  frame_type;
  logic [15:0] id;
  logic [31:0] value;
  logic [7:0]  sum;
  logic [7:0]  sum_next;
  logic [8:0]  sum_wide;
  logic        busy;
  logic        esc;
  tfe_pc_t     pc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last_byte;

  tfe_uop_t    uop;
  logic [7:0]  cur;
  logic        special;
  logic        step;
  logic        take;

  assign cfg.ready       = 1'b1;
  assign item.ready      = !busy;
  assign frame.valid     = out_valid;
  assign frame.out_byte  = out_byte;
  assign frame.last_byte = last_byte;

  assign take = item.valid && !busy;
  assign step = busy && (!out_valid || frame.ready);
  assign uop  = tfe_rom(pc);

  always_comb begin
    case (uop.sel)
      SEL_TYPE:  cur = frame_type;
      SEL_ID_LO: cur = id[7:0];
      SEL_ID_HI: cur = id[15:8];
      SEL_VAL0:  cur = value[7:0];
      SEL_VAL1:  cur = value[15:8];
      SEL_VAL2:  cur = value[23:16];
      SEL_VAL3:  cur = value[31:24];
      SEL_CSUM:  cur = ~sum;
      default:   cur = '0;
    endcase
  end

  assign special = (cur == ESC_BYTE) || (cur == FLAG_BYTE);

  // End-around carry: the carry out is added back into the low byte.
  assign sum_wide = {1'b0, sum} + {1'b0, cur};
  assign sum_next = sum_wide[7:0] + {7'd0, sum_wide[8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type <= TYPE_RESET;
    end else if (cfg.valid) begin
      frame_type <= cfg.frame_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      esc       <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        busy <= 1'b1;
        esc  <= 1'b0;
        pc   <= '0;
      end else if (step) begin
        if (special && !esc) begin
          esc <= 1'b1;
        end else begin
          esc <= 1'b0;
          pc  <= pc + 3'd1;
          if (uop.done) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      id    <= item.sensor_id;
      value <= $unsigned(item.sensor_value);
      sum   <= '0;
    end else if (step) begin
      if (special && !esc) begin
        out_byte  <= ESC_BYTE;
        last_byte <= 1'b0;
      end else begin
        out_byte  <= esc ? (cur ^ ESC_XOR) : cur;
        last_byte <= uop.last;
        if (uop.acc) begin
          sum <= sum_next;
        end
      end
    end
  end

  // An escape pending means the 0x7D half of the pair is in the output.
  `TFE_ASSERT_IMP(a_esc_pair, clk, rst, esc, out_valid && out_byte == ESC_BYTE && !last_byte)
  // A new frame always starts at the top of the program.
  `TFE_ASSERT_NXT(a_frame_start, clk, rst, item.valid && item.ready, busy && pc == '0 && !esc)
  // The final byte never leaves with an escape still owed.
  `TFE_ASSERT_IMP(a_last_clean, clk, rst, out_valid && last_byte, !esc || busy)

endmodule

`default_nettype wire

// ----- dv/tb_telemetry_frame_encoder.sv -----
// Self-checking testbench for the telemetry frame encoder: directed and random readings in, framed bytes checked.
`default_nettype none

module tb_telemetry_frame_encoder;
  import tfe_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 40;
  localparam int STALL_CYCLES = 400;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] value;
  } reading_t;

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
  } line_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfe_item_if  item_ch ();
  tfe_frame_if frame_ch ();
  tfe_cfg_if   cfg_ch ();

  telemetry_frame_encoder u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .frame (frame_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  reading_t   readings_q[$];
  line_beat_t line_q[$];
  logic [7:0] cur_type;
  logic       tx_gaps;
  logic       rx_gaps;
  logic       stall_arm;
  int         stall_left;
  int         tx_wait;
  int         rx_wait;
  int         bad_beats = 0;
  int         cycles = 0;

  // End-around-carry sum over the seven unstuffed bytes ahead of the checksum.
  function automatic logic [7:0] body_sum(input logic [7:0] ftype, input reading_t r);
    logic [55:0] body;
    logic [8:0]  t;
    logic [7:0]  s;
    body = {r.value, r.id, ftype};
    s = 8'h00;
    for (int i = 0; i < 7; i++) begin
      t = {1'b0, s} + {1'b0, body[8*i +: 8]};
      s = t[7:0] + {7'd0, t[8]};
    end
    return s;
  endfunction

  function automatic void encode_frame(input logic [7:0] ftype, input reading_t r);
    logic [63:0] bytes;
    logic [7:0]  b;
    bytes = {8'hFF - body_sum(ftype, r), r.value, r.id, ftype};
    for (int i = 0; i < 8; i++) begin
      b = bytes[8*i +: 8];
      if (b == ESC_BYTE || b == FLAG_BYTE) begin
        line_q.push_back('{data: ESC_BYTE, tail: 1'b0});
        b = b ^ ESC_XOR;
      end
      line_q.push_back('{data: b, tail: (i == 7)});
    end
  endfunction

  // Bytes lean toward the escape codes and the extremes; a quarter of the
  // readings are steered so the checksum itself needs an escape.
  function automatic reading_t random_reading(input logic [7:0] ftype);
    logic [47:0] raw;
    logic [7:0]  target;
    reading_t    r;
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 9))
        0:       raw[8*k +: 8] = ESC_BYTE;
        1:       raw[8*k +: 8] = FLAG_BYTE;
        2:       raw[8*k +: 8] = 8'h00;
        3:       raw[8*k +: 8] = 8'hFF;
        default: raw[8*k +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    r.id    = raw[15:0];
    r.value = raw[47:16];
    if ($urandom_range(0, 3) == 0) begin
      target = $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
      for (int v = 0; v < 256; v++) begin
        r.value[31:24] = 8'(v);
        if (8'(8'hFF - body_sum(ftype, r)) == target) break;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(input logic en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Reading driver
  always @(posedge clk) begin : drive_readings
    reading_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (item_ch.valid && item_ch.ready)
        encode_frame(cur_type, '{id: item_ch.sensor_id, value: item_ch.sensor_value});
      if (!item_ch.valid || item_ch.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          item_ch.valid <= 1'b0;
        end else if (readings_q.size() > 0) begin
          nxt = readings_q.pop_front();
          item_ch.sensor_id    <= nxt.id;
          item_ch.sensor_value <= nxt.value;
          item_ch.valid        <= 1'b1;
          tx_wait = pick_gap(tx_gaps);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Line byte monitor and receiver
  always @(posedge clk) begin : watch_line
    line_beat_t want;
    if (rst) begin
      frame_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (line_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("unexpected line byte %02h last=%0b", frame_ch.out_byte,
                     frame_ch.last_byte);
        end else begin
          want = line_q.pop_front();
          if (frame_ch.out_byte !== want.data || frame_ch.last_byte !== want.tail) begin
            bad_beats++;
            if (bad_beats <= MAX_REPORTS)
              $display("line byte wrong: expected %02h last=%0b, got %02h last=%0b",
                       want.data, want.tail, frame_ch.out_byte, frame_ch.last_byte);
          end
        end
      end
      if (stall_left > 0) begin
        frame_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
        rx_wait = pick_gap(rx_gaps);
      end
    end
  end

  // Long receiver hold-off so the encoder backs up into its input
  always @(posedge clk) begin
    if (rst)
      stall_left <= 0;
    else if (stall_left > 0)
      stall_left <= stall_left - 1;
    else if (stall_arm)
      stall_left <= STALL_CYCLES;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Checked at the falling edge so every beat of the current cycle has landed.
  task automatic drain();
    while (readings_q.size() > 0 || item_ch.valid || line_q.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_type(input logic [7:0] v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.frame_type <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_type     <= v;
  endtask

  initial begin : stimulus
    logic [7:0] ft;
    item_ch.valid        = 1'b0;
    item_ch.sensor_id    = '0;
    item_ch.sensor_value = '0;
    frame_ch.ready       = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.frame_type    = '0;
    tx_gaps              = 1'b1;
    rx_gaps              = 1'b1;
    stall_arm            = 1'b0;
    cur_type             = TYPE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, escape-heavy frames, end-around carry, escaped checksum
    readings_q.push_back('{id: 16'h0000, value: 32'h0000_0000});
    readings_q.push_back('{id: 16'hFFFF, value: 32'hFFFF_FFFF});
    readings_q.push_back('{id: 16'h00FF, value: 32'h0000_0000});
    readings_q.push_back('{id: 16'hFF00, value: 32'h00FF_00FF});
    readings_q.push_back('{id: 16'h7D7E, value: 32'h7E7D_7E7D});
    readings_q.push_back('{id: 16'h7E7D, value: 32'h7D7D_7D7D});
    readings_q.push_back('{id: 16'h0000, value: 32'h0000_0071});  // checksum 0x7E
    readings_q.push_back('{id: 16'h0000, value: 32'h0000_0072});  // checksum 0x7D
    readings_q.push_back('{id: 16'h0000, value: 32'h8000_0000});
    readings_q.push_back('{id: 16'h0000, value: 32'h7FFF_FFFF});
    readings_q.push_back('{id: 16'h8000, value: 32'h0000_0001});
    readings_q.push_back('{id: 16'h0001, value: 32'h8080_8080});
    readings_q.push_back('{id: 16'h5555, value: 32'hAAAA_AAAA});
    readings_q.push_back('{id: 16'hAAAA, value: 32'h5555_5555});
    readings_q.push_back('{id: 16'h007D, value: 32'h0000_0000});
    readings_q.push_back('{id: 16'h7E00, value: 32'hFFFF_FF7E});
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       ft = 8'h00;
        1:       ft = 8'hFF;
        2:       ft = ESC_BYTE;
        3:       ft = FLAG_BYTE;
        4:       ft = 8'($urandom_range(0, 255));
        default: ft = TYPE_RESET;
      endcase
      write_type(ft);
      tx_gaps <= (p != 1 && p != 4);
      rx_gaps <= (p != 1 && p != 3);
      for (int k = 0; k < PHASE_ITEMS; k++)
        readings_q.push_back(random_reading(ft));
      if (p == 2) begin
        @(posedge clk);
        stall_arm <= 1'b1;
        @(posedge clk);
        stall_arm <= 1'b0;
      end
      drain();
    end

    if (bad_beats == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
